FILE: sv/u8v_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 stream validator package
// Field widths, state widths and code point limits used by the validator;
// the input channel interface uses its byte type.
// ----------------------------------------------------------------------------
package u8v_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned LeftW  = 2;
  localparam int unsigned LenW   = 3;
  localparam int unsigned AccumW = 21;

  typedef logic [ByteW-1:0]  byte_t;
  typedef logic [LeftW-1:0]  left_t;
  typedef logic [LenW-1:0]   len_t;
  typedef logic [AccumW-1:0] accum_t;

  localparam len_t SeqLen1 = 3'd1;
  localparam len_t SeqLen2 = 3'd2;
  localparam len_t SeqLen3 = 3'd3;
  localparam len_t SeqLen4 = 3'd4;

  localparam accum_t MinCode2   = 21'h00_0080;
  localparam accum_t MinCode3   = 21'h00_0800;
  localparam accum_t MinCode4   = 21'h01_0000;
  localparam accum_t SurrFirst  = 21'h00_D800;
  localparam accum_t SurrLast   = 21'h00_DFFF;
  localparam accum_t CodeMax    = 21'h10_FFFF;

endpackage

`default_nettype wire

FILE: sv/u8v_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 validator input channel
// Valid/ready channel that carries one byte of a string and its last-byte mark.
// ----------------------------------------------------------------------------
interface u8v_in_if;

  logic             valid;
  logic             ready;
  u8v_pkg::byte_t   data_byte;
  logic             last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);

endinterface

`default_nettype wire

FILE: sv/u8v_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 validator result channel
// Valid/ready channel that carries the running verdict and the end-of-string mark.
// ----------------------------------------------------------------------------
interface u8v_out_if;

  logic valid;
  logic ready;
  logic still_valid;
  logic string_end;

  modport source (output valid, output still_valid, output string_end, input ready);
  modport sink   (input valid, input still_valid, input string_end, output ready);

endinterface

`default_nettype wire

FILE: sv/utf8_stream_validator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 stream validator
// Checks a byte stream for well-formed UTF-8 and returns one verdict per byte.
// ----------------------------------------------------------------------------
// Pipeline: each byte is held in the input register and its verdict in the result register.
// Throughput: one byte per cycle while out_o.ready does not stall the result; the
// decoder state updates as a byte moves from the input to the result register.
// Reset: rst_ni clears the decoder state and both pipeline valids, so the
// block starts at the beginning of a new string.
module utf8_stream_validator_unit (
  input  wire      clk_i,
  input  wire      rst_ni,
  u8v_in_if.sink   in_i,
  u8v_out_if.source out_o
);

  logic                in_valid_q;
  u8v_pkg::byte_t      in_byte_q;
  logic                in_last_q;

  logic                res_valid_q;
  logic                res_still_valid_q;
  logic                res_end_q;

  u8v_pkg::left_t      bytes_left_q, bytes_left_d;
  u8v_pkg::len_t       seq_length_q, seq_length_d;
  u8v_pkg::accum_t     code_accum_q, code_accum_d;
  logic                error_seen_q, error_seen_d;

  logic                advance;
  logic                process;
  logic                verdict;
  u8v_pkg::accum_t     min_code;

  assign advance   = !res_valid_q || out_o.ready;
  assign process   = in_valid_q && advance;
  assign in_i.ready = !in_valid_q || advance;

  always_comb begin
    case (seq_length_q)
      u8v_pkg::SeqLen2: min_code = u8v_pkg::MinCode2;
      u8v_pkg::SeqLen3: min_code = u8v_pkg::MinCode3;
      u8v_pkg::SeqLen4: min_code = u8v_pkg::MinCode4;
      default:          min_code = '0;
    endcase
  end

  always_comb begin
    bytes_left_d = bytes_left_q;
    seq_length_d = seq_length_q;
    code_accum_d = code_accum_q;
    error_seen_d = error_seen_q;

    if (bytes_left_q == '0) begin
      if (in_byte_q[7] == 1'b0) begin
        seq_length_d = u8v_pkg::SeqLen1;
        code_accum_d = {13'd0, in_byte_q};
      end else if (in_byte_q[7:5] == 3'b110) begin
        seq_length_d = u8v_pkg::SeqLen2;
        bytes_left_d = 2'd1;
        code_accum_d = {16'd0, in_byte_q[4:0]};
      end else if (in_byte_q[7:4] == 4'b1110) begin
        seq_length_d = u8v_pkg::SeqLen3;
        bytes_left_d = 2'd2;
        code_accum_d = {17'd0, in_byte_q[3:0]};
      end else if (in_byte_q[7:3] == 5'b11110) begin
        seq_length_d = u8v_pkg::SeqLen4;
        bytes_left_d = 2'd3;
        code_accum_d = {18'd0, in_byte_q[2:0]};
      end else begin
        error_seen_d = 1'b1;
        seq_length_d = '0;
        code_accum_d = '0;
      end
    end else if (in_byte_q[7:6] != 2'b10) begin
      error_seen_d = 1'b1;
      bytes_left_d = '0;
      seq_length_d = '0;
      code_accum_d = '0;
    end else begin
      code_accum_d = {code_accum_q[14:0], in_byte_q[5:0]};
      bytes_left_d = bytes_left_q - 2'd1;
      if (bytes_left_d == '0) begin
        if ((code_accum_d < min_code) ||
            ((code_accum_d >= u8v_pkg::SurrFirst) && (code_accum_d <= u8v_pkg::SurrLast)) ||
            (code_accum_d > u8v_pkg::CodeMax)) begin
          error_seen_d = 1'b1;
        end
      end
    end

    if (in_last_q && (bytes_left_d != '0)) begin
      error_seen_d = 1'b1;
    end

    verdict = !error_seen_d;

    if (in_last_q) begin
      bytes_left_d = '0;
      seq_length_d = '0;
      code_accum_d = '0;
      error_seen_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      res_valid_q  <= 1'b0;
      bytes_left_q <= '0;
      seq_length_q <= '0;
      code_accum_q <= '0;
      error_seen_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance) begin
        res_valid_q <= in_valid_q;
      end
      if (process) begin
        bytes_left_q <= bytes_left_d;
        seq_length_q <= seq_length_d;
        code_accum_q <= code_accum_d;
        error_seen_q <= error_seen_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_byte_q <= in_i.data_byte;
      in_last_q <= in_i.last_byte;
    end
    if (process) begin
      res_still_valid_q <= verdict;
      res_end_q         <= in_last_q;
    end
  end

  assign out_o.valid       = res_valid_q;
  assign out_o.still_valid = res_still_valid_q;
  assign out_o.string_end  = res_end_q;

endmodule

`default_nettype wire
